### rtl/core/hdf_pkg.sv
// ----------------------------------------------------------------------------
// HDLC deframer package
// Shared types, constants and decode functions of the HDLC deframer.
// ----------------------------------------------------------------------------
package hdf_pkg;

   // Special bytes of the asynchronous framing.
   localparam logic [7:0] FLAG_BYTE    = 8'h7E;
   localparam logic [7:0] ESC_BYTE     = 8'h7D;
   localparam logic [7:0] ESC_FLAG     = 8'h5E;
   localparam logic [7:0] ESC_ESC      = 8'h5D;

   // PPP FCS-16 constants.
   localparam logic [15:0] FCS_INIT    = 16'hFFFF;
   localparam logic [15:0] FCS_GOOD    = 16'hF0B8;
   localparam logic [15:0] FCS_POLY    = 16'h8408;

   // Width of the reported payload count.
   localparam int PAYLOAD_COUNT_W      = 11;

   // Number of content bytes that make a complete frame (address, control, FCS).
   localparam int MIN_CONTENT          = 4;

   // Response word kinds.
   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } item_kind_type;

   // Error codes of the status word.
   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_ESC_FLAG   = 3'd1,
      ERR_BAD_ESC    = 3'd2,
      ERR_FCS        = 3'd3,
      ERR_SHORT      = 3'd4,
      ERR_OVERFLOW   = 3'd5
   } error_code_type;

   // Decoded frame kinds.
   typedef enum logic [4:0] {
      FK_UNSET = 5'd0,
      FK_I     = 5'd1,
      FK_RR    = 5'd2,
      FK_RNR   = 5'd3,
      FK_REJ   = 5'd4,
      FK_SREJ  = 5'd5,
      FK_UI    = 5'd6,
      FK_SIM   = 5'd7,
      FK_SARM  = 5'd8,
      FK_UP    = 5'd9,
      FK_SABM  = 5'd10,
      FK_DISC  = 5'd11,
      FK_UA    = 5'd12,
      FK_SNRM  = 5'd13,
      FK_CMDR  = 5'd14,
      FK_TEST  = 5'd15,
      FK_XID   = 5'd16
   } frame_kind_type;

   // Word passed from the front end to the back end through the queue.
   typedef struct packed {
      logic       is_flag;      // flag byte seen
      logic [7:0] data;         // unescaped content byte
      logic       bad_esc;      // content byte came from an invalid escape
      logic       esc_pending;  // word came straight after an escape (an error on a flag)
   } event_type;

   // Response word as held in the output register.
   typedef struct packed {
      item_kind_type              item_kind;
      logic [7:0]                 payload_byte;
      logic                       frame_good;
      error_code_type             error_code;
      logic [7:0]                 station_address;
      frame_kind_type             frame_kind;
      logic                       poll_final;
      logic [2:0]                 send_seq;
      logic [2:0]                 recv_seq;
      logic [PAYLOAD_COUNT_W-1:0] payload_count;
   } rsp_word_type;

   // Unnumbered frame kinds, indexed by control bits {7:5, 3:2}.
   localparam frame_kind_type U_KIND_TABLE [32] = '{
      FK_UI,    FK_SIM,   FK_UNSET, FK_SARM,  FK_UP,    FK_UNSET, FK_UNSET, FK_SABM,
      FK_DISC,  FK_UNSET, FK_UNSET, FK_UNSET, FK_UA,    FK_UNSET, FK_UNSET, FK_UNSET,
      FK_SNRM,  FK_CMDR,  FK_UNSET, FK_UNSET, FK_UNSET, FK_UNSET, FK_UNSET, FK_UNSET,
      FK_UNSET, FK_UNSET, FK_UNSET, FK_UNSET, FK_TEST,  FK_XID,   FK_UNSET, FK_UNSET
   };

   // Decode the frame kind from a control byte.
   function automatic frame_kind_type decode_kind(input logic [7:0] ctrl);
      frame_kind_type kind;
      if (!ctrl[0]) begin
         kind = FK_I;
      end else if (!ctrl[1]) begin
         kind = frame_kind_type'(5'(FK_RR) + {3'b000, ctrl[3:2]});
      end else begin
         kind = U_KIND_TABLE[{ctrl[7:5], ctrl[3:2]}];
      end
      return kind;
   endfunction

   // One byte of the reflected FCS-16 update.
   function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
      logic [15:0] acc;
      acc = fcs ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ FCS_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

endpackage

### rtl/core/hdf_channels.sv
// ----------------------------------------------------------------------------
// HDLC deframer channels
// Valid/ready channels for received bytes and for deframer responses.
// ----------------------------------------------------------------------------
interface hdf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hdf_rsp_if;
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic [7:0]  payload_byte;
   logic        frame_good;
   logic [2:0]  error_code;
   logic [7:0]  station_address;
   logic [4:0]  frame_kind;
   logic        poll_final;
   logic [2:0]  send_seq;
   logic [2:0]  recv_seq;
   logic [10:0] payload_count;

   modport source (output valid, input ready, output item_kind, output payload_byte,
                   output frame_good, output error_code, output station_address,
                   output frame_kind, output poll_final, output send_seq,
                   output recv_seq, output payload_count);
   modport sink   (input valid, output ready, input item_kind, input payload_byte,
                   input frame_good, input error_code, input station_address,
                   input frame_kind, input poll_final, input send_seq,
                   input recv_seq, input payload_count);
endinterface

### rtl/core/hdlc_async_deframer.sv
// ----------------------------------------------------------------------------
// HDLC asynchronous deframer
// Byte-stuffed HDLC receiver with PPP FCS-16 check and frame decode.
// ----------------------------------------------------------------------------
// The deframer takes one received byte per clock on req_bus while the
// response side does not stall, and gives payload bytes of I and UI frames
// and one status word per closed frame on rsp_bus. Bytes are dropped until
// a 0x7E flag opens a frame. A byte moves from the input through the front
// end into a two-entry queue; the back end takes it from the queue and
// loads the output register with the word it causes. The back end's FCS-16
// update and frame decode set the sustained rate of one byte per clock.
// Payload bytes leave two bytes late, so the FCS is never delivered. Frames
// longer than MAX_FRAME content bytes are truncated and reported as
// overflow. After a good frame the closing flag returns the block to
// hunting; after a bad frame it opens the next frame.
module hdlc_async_deframer
   import hdf_pkg::*;
#(
   parameter int MAX_FRAME = 2048
) (
   input  logic      clock,
   input  logic      reset,
   hdf_req_if.sink   req_bus,
   hdf_rsp_if.source rsp_bus
);

   logic      front_valid;
   event_type front_word;
   logic      front_ready;
   logic      back_valid;
   event_type back_word;
   logic      back_ready;

   // Destuffing and classification.
   hdf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .ev_valid (front_valid),
      .ev_word  (front_word),
      .ev_ready (front_ready)
   );

   // Decoupling queue.
   hdf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_word  (front_word),
      .push_ready (front_ready),
      .pop_valid  (back_valid),
      .pop_word   (back_word),
      .pop_ready  (back_ready)
   );

   // Frame tracking, FCS check and response generation.
   hdf_back #(
      .MAX_FRAME (MAX_FRAME)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .ev_valid (back_valid),
      .ev_word  (back_word),
      .ev_ready (back_ready),
      .rsp_bus  (rsp_bus)
   );

endmodule

### rtl/core/hdf_front.sv
// ----------------------------------------------------------------------------
// HDLC deframer front end
// Removes byte stuffing and classifies each received word but an escape as
// a flag or a content byte for the back end.
// ----------------------------------------------------------------------------
module hdf_front
   import hdf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   hdf_req_if.sink   req_bus,
   output logic      ev_valid,
   output event_type ev_word,
   input  logic      ev_ready
);

   logic esc_ff;
   logic esc_in;
   logic accept;

   assign req_bus.ready = ev_ready;
   assign accept        = req_bus.valid && ev_ready;

   // Classify the incoming word and work out the escape state.
   always_comb begin
      esc_in              = esc_ff;
      ev_valid            = 1'b0;
      ev_word.is_flag     = 1'b0;
      ev_word.data        = req_bus.rx_byte;
      ev_word.bad_esc     = 1'b0;
      ev_word.esc_pending = esc_ff;
      if (req_bus.rx_byte == FLAG_BYTE) begin
         // A flag always passes on and ends any escape.
         ev_valid        = req_bus.valid;
         ev_word.is_flag = 1'b1;
         esc_in          = 1'b0;
      end else if (esc_ff) begin
         ev_valid = req_bus.valid;
         esc_in   = 1'b0;
         if (req_bus.rx_byte == ESC_FLAG) begin
            ev_word.data = FLAG_BYTE;
         end else if (req_bus.rx_byte == ESC_ESC) begin
            ev_word.data = ESC_BYTE;
         end else begin
            ev_word.bad_esc = 1'b1;
         end
      end else if (req_bus.rx_byte == ESC_BYTE) begin
         esc_in = 1'b1;
      end else begin
         ev_valid = req_bus.valid;
      end
   end

   // The escape state only moves when a word is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff <= 1'b0;
      end else if (accept) begin
         esc_ff <= esc_in;
      end
   end

endmodule

### rtl/core/hdf_queue.sv
// ----------------------------------------------------------------------------
// HDLC deframer event queue
// A two-entry queue between the front and back ends, so that each side can
// stall without holding up the other.
// ----------------------------------------------------------------------------
module hdf_queue
   import hdf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  event_type push_word,
   output logic      push_ready,
   output logic      pop_valid,
   output event_type pop_word,
   input  logic      pop_ready
);

   localparam int DEPTH = 2;

   event_type  entry_ff [DEPTH];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (fill_ff != 2'(DEPTH));
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_word   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill level updates.
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

### rtl/core/hdf_back.sv
// ----------------------------------------------------------------------------
// HDLC deframer back end
// Tracks the frame, checks the FCS, emits delayed payload words and builds
// the end-of-frame status word in the output register.
// ----------------------------------------------------------------------------
module hdf_back
   import hdf_pkg::*;
#(
   parameter int MAX_FRAME = 2048
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      ev_valid,
   input  event_type ev_word,
   output logic      ev_ready,
   hdf_rsp_if.source rsp_bus
);

   localparam int CNT_W = $clog2(MAX_FRAME + 1);
   localparam int PC_W  = (CNT_W > PAYLOAD_COUNT_W) ? CNT_W : PAYLOAD_COUNT_W;

   // Frame state.
   logic             in_frame_ff,  in_frame_in;
   logic [15:0]      fcs_ff,       fcs_in;
   logic [CNT_W-1:0] count_ff,     count_in;
   logic [7:0]       addr_ff,      addr_in;
   logic [7:0]       ctrl_ff,      ctrl_in;
   logic [7:0]       delay0_ff,    delay0_in;
   logic [7:0]       delay1_ff,    delay1_in;
   logic             bad_esc_ff,   bad_esc_in;
   logic             overflow_ff,  overflow_in;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_ff,       rsp_in;

   logic             take;
   frame_kind_type   kind;
   error_code_type   err;
   logic             carries;
   logic [PC_W-1:0]  pc_wide;

   assign ev_ready = !rsp_valid_ff || rsp_bus.ready;
   assign take     = ev_valid && ev_ready;

   // Decode of the latched control byte.
   assign kind    = (count_ff >= CNT_W'(2)) ? decode_kind(ctrl_ff) : FK_UNSET;
   assign carries = (kind == FK_I) || (kind == FK_UI);
   assign pc_wide = PC_W'(count_ff) - PC_W'(MIN_CONTENT);

   // Error in priority order.
   always_comb begin
      if (ev_word.esc_pending) begin
         err = ERR_ESC_FLAG;
      end else if (overflow_ff) begin
         err = ERR_OVERFLOW;
      end else if (count_ff < CNT_W'(MIN_CONTENT)) begin
         err = ERR_SHORT;
      end else if (bad_esc_ff) begin
         err = ERR_BAD_ESC;
      end else if (fcs_ff != FCS_GOOD) begin
         err = ERR_FCS;
      end else begin
         err = ERR_NONE;
      end
   end

   // Next state of the frame and the output register.
   always_comb begin
      in_frame_in  = in_frame_ff;
      fcs_in       = fcs_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      ctrl_in      = ctrl_ff;
      delay0_in    = delay0_ff;
      delay1_in    = delay1_ff;
      bad_esc_in   = bad_esc_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_in       = rsp_ff;

      if (take) begin
         if (ev_word.is_flag) begin
            // Every flag restarts the frame state.
            fcs_in      = FCS_INIT;
            count_in    = '0;
            addr_in     = 8'h00;
            ctrl_in     = 8'h00;
            bad_esc_in  = 1'b0;
            overflow_in = 1'b0;
            if (!in_frame_ff) begin
               in_frame_in = 1'b1;
            end else if ((count_ff != '0) || ev_word.esc_pending) begin
               // Closing flag of a frame with content: report its status.
               rsp_valid_in           = 1'b1;
               rsp_in                 = '0;
               rsp_in.item_kind       = KIND_STATUS;
               rsp_in.frame_good      = (err == ERR_NONE);
               rsp_in.error_code      = err;
               rsp_in.station_address = addr_ff;
               rsp_in.frame_kind      = kind;
               // The P/F bit is reported whenever a control byte arrived.
               if (count_ff >= CNT_W'(2)) begin
                  rsp_in.poll_final = ctrl_ff[4];
               end
               if ((kind == FK_I) || (kind == FK_RR) || (kind == FK_RNR)
                   || (kind == FK_REJ) || (kind == FK_SREJ)) begin
                  rsp_in.recv_seq = ctrl_ff[7:5];
               end
               if (kind == FK_I) begin
                  rsp_in.send_seq = ctrl_ff[3:1];
               end
               if (carries && (count_ff >= CNT_W'(MIN_CONTENT))) begin
                  rsp_in.payload_count = pc_wide[PAYLOAD_COUNT_W-1:0];
               end
               // A good frame goes back to hunting; a bad one shares its flag.
               if (err == ERR_NONE) begin
                  in_frame_in = 1'b0;
               end
            end
         end else if (in_frame_ff) begin
            if (ev_word.bad_esc) begin
               bad_esc_in = 1'b1;
            end
            if (count_ff >= CNT_W'(MAX_FRAME)) begin
               // Bytes beyond the limit are dropped.
               overflow_in = 1'b1;
            end else begin
               if (count_ff == '0) begin
                  addr_in = ev_word.data;
               end
               if (count_ff == CNT_W'(1)) begin
                  ctrl_in = ev_word.data;
               end
               // Payload leaves two bytes late, so the FCS never does.
               if ((count_ff >= CNT_W'(MIN_CONTENT)) && carries) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in              = '0;
                  rsp_in.item_kind    = KIND_PAYLOAD;
                  rsp_in.payload_byte = delay1_ff;
               end
               delay1_in = delay0_ff;
               delay0_in = ev_word.data;
               fcs_in    = fcs_update(fcs_ff, ev_word.data);
               count_in  = count_ff + CNT_W'(1);
            end
         end
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         fcs_ff       <= FCS_INIT;
         count_ff     <= '0;
         addr_ff      <= 8'h00;
         ctrl_ff      <= 8'h00;
         bad_esc_ff   <= 1'b0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_frame_ff  <= in_frame_in;
         fcs_ff       <= fcs_in;
         count_ff     <= count_in;
         addr_ff      <= addr_in;
         ctrl_ff      <= ctrl_in;
         bad_esc_ff   <= bad_esc_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      delay0_ff <= delay0_in;
      delay1_ff <= delay1_in;
      rsp_ff    <= rsp_in;
   end

   // Drive the response channel from the output register.
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.item_kind       = rsp_ff.item_kind;
   assign rsp_bus.payload_byte    = rsp_ff.payload_byte;
   assign rsp_bus.frame_good      = rsp_ff.frame_good;
   assign rsp_bus.error_code      = rsp_ff.error_code;
   assign rsp_bus.station_address = rsp_ff.station_address;
   assign rsp_bus.frame_kind      = rsp_ff.frame_kind;
   assign rsp_bus.poll_final      = rsp_ff.poll_final;
   assign rsp_bus.send_seq        = rsp_ff.send_seq;
   assign rsp_bus.recv_seq        = rsp_ff.recv_seq;
   assign rsp_bus.payload_count   = rsp_ff.payload_count;

endmodule
